>>> src/pids_pkg.sv
// Package for the per-identifier duplicate suppressor.
// Holds the word types, the outcome codes, the controller state type and the
// command and status bundles. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pids_pkg;

    // Word accepted on the request channel.
    typedef struct packed {
        logic [31:0] message_id;
        logic [31:0] tick_stamp;
    } req_word_t;

    // Word delivered on the response channel.
    typedef struct packed {
        logic       drop;
        logic [1:0] outcome;
    } rsp_word_t;

    // One table entry as it sits in the slot memory.
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] tick;
    } slot_t;

    // Outcome codes.
    localparam logic [1:0] OUT_NEW       = 2'd0;
    localparam logic [1:0] OUT_UPDATED   = 2'd1;
    localparam logic [1:0] OUT_DUPLICATE = 2'd2;
    localparam logic [1:0] OUT_FULL      = 2'd3;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_REPORT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
        logic report;
    } pids_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } pids_status_t;

endpackage

`default_nettype wire

>>> src/pids_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Stands alone; used for the slot table of the duplicate suppressor.
`timescale 1ns / 1ps
`default_nettype none

module pids_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/pids_ctrl.sv
// Controller state machine of the duplicate suppressor.
// Depends on pids_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module pids_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire pids_pkg::pids_status_t status,
    output pids_pkg::pids_cmd_t         cmd
);

    import pids_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (status.out_free)
                begin
                    cmd.report = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/pids_datapath.sv
// Datapath of the duplicate suppressor: request hold, slot scan, fill count,
// table update and the response register. Depends on pids_pkg and pids_ram.
`timescale 1ns / 1ps
`default_nettype none

module pids_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pids_pkg::req_word_t req_word,
    input  wire pids_pkg::pids_cmd_t cmd,
    output pids_pkg::pids_status_t   status,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output pids_pkg::rsp_word_t      rsp_word
);

    import pids_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

    // Request being worked on.
    req_word_t       item_reg;

    // Scan state.
    logic [CW-1:0]   scan_addr_reg;
    logic [CW-1:0]   scan_addr_next;
    logic            pend_reg;
    logic            pend_next;
    logic [AW-1:0]   pend_addr_reg;
    logic            hit_reg;
    logic            hit_next;
    logic [AW-1:0]   hit_addr_reg;
    logic            tick_eq_reg;

    // Table fill level; slots below it are the valid ones.
    logic [CW-1:0]   fill_count_reg;
    logic [CW-1:0]   fill_count_next;

    // Outcome of the current request and the response register.
    logic [1:0]      outcome_reg;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    rsp_word_t       rsp_word_reg;

    // Memory ports.
    logic            rd_en;
    slot_t           rd_slot;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    slot_t           wr_slot;

    logic            issue;
    logic            match;
    logic            full;
    logic [1:0]      outcome_calc;
    logic            scan_done;
    logic            out_free;

    pids_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_slot),
        .rd_en   (rd_en),
        .rd_addr (scan_addr_reg[AW-1:0]),
        .rd_data (rd_slot)
    );

    // Scan: issue one read a cycle and compare the word read the cycle before.
    always_comb
    begin
        issue          = cmd.scan && (scan_addr_reg < fill_count_reg);
        rd_en          = issue;
        match          = cmd.scan && pend_reg && (rd_slot.id == item_reg.message_id);
        scan_done      = match || (!pend_reg && !issue);
        scan_addr_next = scan_addr_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        if (cmd.load)
        begin
            scan_addr_next = '0;
            pend_next      = 1'b0;
            hit_next       = 1'b0;
        end
        else if (cmd.scan)
        begin
            pend_next = issue;
            if (issue)
            begin
                scan_addr_next = scan_addr_reg + CW'(1);
            end
            if (match)
            begin
                hit_next = 1'b1;
            end
        end
    end

    // Decision and table write on commit.
    always_comb
    begin
        full    = (fill_count_reg == DEPTH_CNT);
        wr_slot = '{id: item_reg.message_id, tick: item_reg.tick_stamp};
        if (hit_reg)
        begin
            outcome_calc = tick_eq_reg ? OUT_DUPLICATE : OUT_UPDATED;
            wr_addr      = hit_addr_reg;
            wr_en        = cmd.commit && !tick_eq_reg;
        end
        else
        begin
            outcome_calc = full ? OUT_FULL : OUT_NEW;
            wr_addr      = fill_count_reg[AW-1:0];
            wr_en        = cmd.commit && !full;
        end
        fill_count_next = fill_count_reg;
        if (cmd.commit && !hit_reg && !full)
        begin
            fill_count_next = fill_count_reg + CW'(1);
        end
    end

    // Response register handshake.
    always_comb
    begin
        out_free       = !rsp_valid_reg || !rsp_stall;
        rsp_valid_next = rsp_valid_reg;
        if (cmd.report)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Status back to the controller.
    assign status = '{scan_done: scan_done, out_free: out_free};

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg  <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            fill_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            scan_addr_reg  <= scan_addr_next;
            pend_reg       <= pend_next;
            hit_reg        <= hit_next;
            fill_count_reg <= fill_count_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req_word;
        end
        if (issue)
        begin
            pend_addr_reg <= scan_addr_reg[AW-1:0];
        end
        if (match)
        begin
            hit_addr_reg <= pend_addr_reg;
            tick_eq_reg  <= (rd_slot.tick == item_reg.tick_stamp);
        end
        if (cmd.commit)
        begin
            outcome_reg <= outcome_calc;
        end
        if (cmd.report)
        begin
            rsp_word_reg.drop    <= (outcome_reg == OUT_DUPLICATE);
            rsp_word_reg.outcome <= outcome_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

`default_nettype wire

>>> src/per_id_duplicate_suppressor_unit.sv
// Per-identifier duplicate suppressor, top level.
// Request channel: req_valid, req_stall, req_word (message_id, tick_stamp).
// Response channel: rsp_valid, rsp_stall, rsp_word (drop, outcome).
// Each request word yields exactly one response word, in order. The block
// keeps a table of TABLE_DEPTH identifiers with their last tick; slots fill
// from the lowest upward and are never evicted, so a fill count marks the
// valid ones. The table is searched one slot per cycle through a memory with
// a registered read, the read of one slot overlapping the compare of the
// previous one. From acceptance to the response register a request passes
// through the scan, commit and report states; the scan covers the F filled
// slots (F at most TABLE_DEPTH) and ends early when a match is found. One
// request is worked on at a time; the next is accepted as soon as the
// previous response sits in the output register, even if the receiver has
// not yet taken it.
// Reset empties the table at once (the fill count clears) with no sweep.
// While the receiver stalls, the response word holds and a finished request
// waits for the output register before the next request is taken.
// Depends on pids_pkg, pids_ctrl, pids_datapath and pids_ram.
`timescale 1ns / 1ps
`default_nettype none

module per_id_duplicate_suppressor_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire pids_pkg::req_word_t req_word,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output pids_pkg::rsp_word_t      rsp_word
);

    import pids_pkg::*;

    pids_cmd_t    cmd;
    pids_status_t status;

    pids_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pids_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_word  (req_word),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

`default_nettype wire

>>> test/pids_checker.sv
// Scoreboard for the per-identifier duplicate suppressor.
// Watches both channels, keeps its own copy of the identifier table and
// compares every response word with the verdict it predicts. Uses pids_pkg.
`timescale 1ns / 1ps

module pids_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic                req_stall,
    input  wire pids_pkg::req_word_t req_word,
    input  wire logic                rsp_valid,
    input  wire logic                rsp_stall,
    input  wire pids_pkg::rsp_word_t rsp_word,
    output int                       fail_count,
    output int                       pending
);

    import pids_pkg::*;

    // Shadow copy of the identifier table.
    logic        seen_valid [TABLE_DEPTH];
    logic [31:0] seen_id    [TABLE_DEPTH];
    logic [31:0] seen_tick  [TABLE_DEPTH];

    // Verdicts waiting for their response words, oldest first.
    rsp_word_t expected_verdicts [$];

    // Looks the packet up in the shadow table, updates the table the way the
    // block must, and returns the verdict.
    function automatic rsp_word_t classify_packet(input req_word_t pkt);
        int        hit;
        int        free_slot;
        rsp_word_t verdict;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (seen_valid[i])
            begin
                if (hit < 0 && seen_id[i] == pkt.message_id)
                    hit = i;
            end
            else if (free_slot < 0)
            begin
                free_slot = i;
            end
        end

        verdict.outcome = OUT_FULL;
        if (hit >= 0)
        begin
            if (seen_tick[hit] == pkt.tick_stamp)
            begin
                verdict.outcome = OUT_DUPLICATE;
            end
            else
            begin
                seen_tick[hit]  = pkt.tick_stamp;
                verdict.outcome = OUT_UPDATED;
            end
        end
        else if (free_slot >= 0)
        begin
            seen_id[free_slot]    = pkt.message_id;
            seen_tick[free_slot]  = pkt.tick_stamp;
            seen_valid[free_slot] = 1'b1;
            verdict.outcome       = OUT_NEW;
        end
        verdict.drop = (verdict.outcome == OUT_DUPLICATE);
        return verdict;
    endfunction

    // Response words are checked before the request word of the same edge
    // is predicted; a response can never belong to a request of that edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                seen_valid[i] = 1'b0;
            expected_verdicts.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: response word with none expected: drop %0b outcome %0d",
                             $time, rsp_word.drop, rsp_word.outcome);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (rsp_word.drop !== want.drop)
                    begin
                        fail_count++;
                        $display("%0t: drop mismatch: expected %0b, actual %0b",
                                 $time, want.drop, rsp_word.drop);
                    end
                    if (rsp_word.outcome !== want.outcome)
                    begin
                        fail_count++;
                        $display("%0t: outcome mismatch: expected %0d, actual %0d",
                                 $time, want.outcome, rsp_word.outcome);
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_verdicts.push_back(classify_packet(req_word));
            pending = expected_verdicts.size();
        end
    end

endmodule

>>> test/per_id_duplicate_suppressor_unit_test.sv
// Testbench top for the per-identifier duplicate suppressor.
// Drives packets and random back-pressure into the block, and gives the
// verdict from pids_checker. Uses pids_pkg and the block's top level.
`timescale 1ns / 1ps

module per_id_duplicate_suppressor_unit_test;

    import pids_pkg::*;

    localparam int TABLE_DEPTH      = 16;
    localparam int RANDOM_PACKETS   = 1900;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 50;
    localparam int LIMIT_CYCLES     = 400000;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req_word;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp_word;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // Flags of the two driving processes; burst_mode and hold_request are shared.
    bit burst_mode   = 1'b0;
    bit hold_request = 1'b0;
    bit hold_taken   = 1'b0;

    // Identifiers the table should hold, with the last tick sent for each.
    logic [31:0] pool_id   [TABLE_DEPTH];
    logic [31:0] pool_tick [TABLE_DEPTH];
    int          pool_count = 0;

    per_id_duplicate_suppressor_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    pids_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_word   (req_word),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_word   (rsp_word),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock and the single reset at the start.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one packet word after a random gap (none in burst mode) and holds it until taken.
    // Also tracks which identifiers should now sit in the table.
    task automatic send_packet(input logic [31:0] id, input logic [31:0] tick);
        int gap;
        bit known;
        gap = burst_mode ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= '{message_id: id, tick_stamp: tick};
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));

        known = 1'b0;
        for (int k = 0; k < pool_count; k++)
        begin
            if (pool_id[k] == id)
            begin
                pool_tick[k] = tick;
                known        = 1'b1;
            end
        end
        if (!known && pool_count < TABLE_DEPTH)
        begin
            pool_id[pool_count]   = id;
            pool_tick[pool_count] = tick;
            pool_count++;
        end
    endtask

    // Receiver: random stall before every word, one long hold-off in the
    // middle of the run, none at all during the burst stretch.
    initial
    begin : response_side
        int gap;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request && !hold_taken)
            begin
                gap        = LONG_HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            else if (burst_mode)
            begin
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, 3);
            end
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(rsp_valid && !rsp_stall));
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        int          roll;
        int          pick;
        logic [31:0] id;
        logic [31:0] tick;
        req_valid = 1'b0;
        req_word  = '0;
        @(posedge rst_n);
        @(posedge clk);

        // New identifier, exact duplicate, then tick changes both ways,
        // including an older tick after a newer one.
        send_packet(32'h0000_0000, 32'h0000_0000);
        send_packet(32'h0000_0000, 32'h0000_0000);
        send_packet(32'h0000_0000, 32'hFFFF_FFFF);
        send_packet(32'h0000_0000, 32'h0000_0000);
        send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_packet(32'hFFFF_FFFF, 32'h0000_0000);
        send_packet(32'hAAAA_AAAA, 32'h5555_5555);
        send_packet(32'h5555_5555, 32'hAAAA_AAAA);
        send_packet(32'hAAAA_AAAA, 32'h5555_5555);

        // Fill the remaining slots with one-hot identifiers.
        for (int n = 0; n < TABLE_DEPTH - 4; n++)
            send_packet(32'h1 << n, ~(32'h1 << n));

        // Table full: unknown identifiers pass untouched, known ones still work.
        send_packet(32'h1234_5678, 32'h0000_0000);
        send_packet(32'h1234_5678, 32'h0000_0000);
        send_packet(32'h0000_0001, 32'hFFFF_FFFE);
        send_packet(32'h0000_0002, 32'h0000_0002);

        // Random traffic against the full table: known identifiers with a
        // repeated or changed tick, near misses of known ones, and strangers.
        for (int n = 0; n < RANDOM_PACKETS; n++)
        begin
            burst_mode = (n >= 600 && n < 800);
            if (n == 1200)
                hold_request = 1'b1;
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, pool_count - 1);
            if (roll < 60)
            begin
                id   = pool_id[pick];
                roll = $urandom_range(0, 99);
                if (roll < 50)
                    tick = pool_tick[pick];
                else if (roll < 75)
                    tick = $urandom;
                else
                    tick = pool_tick[pick] ^ (32'h1 << $urandom_range(0, 31));
            end
            else if (roll < 75)
            begin
                id   = pool_id[pick] ^ (32'h1 << $urandom_range(0, 31));
                tick = $urandom;
            end
            else
            begin
                id   = $urandom;
                tick = $urandom;
            end
            send_packet(id, tick);
        end
        req_valid <= 1'b0;
        burst_mode = 1'b0;

        // Let the last prediction land, drain, then allow for stray words.
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
